### sv/ibd_pkg.sv
// types, constants and field layout helpers for the indoor bike data parser
package ibd_pkg;

   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned FLAG_W     = 7;
   localparam int unsigned VALUE_W    = 16;
   localparam int unsigned POS_W      = 8;
   localparam int unsigned OFS_W      = 5;
   localparam int unsigned RSP_DATA_W = 56;

   localparam logic [POS_W-1:0] POS_MAX = '1;

   // flag bit positions
   localparam int unsigned FLAG_SPEED_ABSENT = 0;
   localparam int unsigned FLAG_AVG_SPEED    = 1;
   localparam int unsigned FLAG_CADENCE      = 2;
   localparam int unsigned FLAG_AVG_CADENCE  = 3;
   localparam int unsigned FLAG_DISTANCE     = 4;
   localparam int unsigned FLAG_RESISTANCE   = 5;
   localparam int unsigned FLAG_POWER        = 6;

   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic              last_byte;
   } item_type;

   typedef struct packed {
      logic                      parse_ok;
      logic                      speed_present;
      logic [VALUE_W-1:0]        speed_raw;
      logic                      cadence_present;
      logic [VALUE_W-1:0]        cadence_raw;
      logic                      power_present;
      logic signed [VALUE_W-1:0] power_watts;
   } result_type;

   typedef struct packed {
      logic [OFS_W-1:0] speed_at;
      logic [OFS_W-1:0] cadence_at;
      logic [OFS_W-1:0] power_at;
      logic [OFS_W-1:0] end_at;
   } layout_type;

   // byte offsets of the fields that follow the two flag bytes
   function automatic layout_type lay_out(input logic [FLAG_W-1:0] f);
      layout_type       l;
      logic [OFS_W-1:0] at;
      at = OFS_W'(2);
      l.speed_at = at;
      if (!f[FLAG_SPEED_ABSENT]) at = at + OFS_W'(2);
      if (f[FLAG_AVG_SPEED]) at = at + OFS_W'(2);
      l.cadence_at = at;
      if (f[FLAG_CADENCE]) at = at + OFS_W'(2);
      if (f[FLAG_AVG_CADENCE]) at = at + OFS_W'(2);
      if (f[FLAG_DISTANCE]) at = at + OFS_W'(3);
      if (f[FLAG_RESISTANCE]) at = at + OFS_W'(2);
      l.power_at = at;
      if (f[FLAG_POWER]) at = at + OFS_W'(2);
      l.end_at = at;
      return l;
   endfunction

   // little-endian capture of a 16-bit field starting at offset at
   function automatic logic [VALUE_W-1:0] take_byte(
      input logic [VALUE_W-1:0] v,
      input logic [POS_W-1:0]   pos,
      input logic [OFS_W-1:0]   at,
      input logic [BYTE_W-1:0]  b
   );
      logic [POS_W-1:0] at_ext;
      at_ext = {{(POS_W-OFS_W){1'b0}}, at};
      if (pos == at_ext) return {v[VALUE_W-1:BYTE_W], b};
      if (pos == at_ext + POS_W'(1)) return {b, v[BYTE_W-1:0]};
      return v;
   endfunction

endpackage

### sv/ibd_input_stage.sv
// input register stage for notification bytes
module ibd_input_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  ibd_pkg::item_type in_item,
   output logic              hold_valid,
   output ibd_pkg::item_type hold_item,
   input  logic              advance
);
   import ibd_pkg::*;

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;

   assign in_ready = !valid_ff || advance;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (in_ready) begin
         valid_in = in_valid;
         item_in  = in_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign hold_valid = valid_ff;
   assign hold_item  = item_ff;

endmodule

### sv/ibd_parse_core.sv
// per-notification parse state and result logic
module ibd_parse_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  ibd_pkg::item_type   item,
   output ibd_pkg::result_type result
);
   import ibd_pkg::*;

   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [FLAG_W-1:0]  flags_ff, flags_in;
   logic [VALUE_W-1:0] speed_ff, speed_in;
   logic [VALUE_W-1:0] cadence_ff, cadence_in;
   logic [VALUE_W-1:0] power_ff, power_in;
   layout_type         lay;
   logic               past_flags;
   logic [POS_W:0]     len;
   logic               sp, cp, pp;

   // flags live in the register from byte 1 on; byte 0 results are all zero anyway
   assign lay        = lay_out(flags_ff);
   assign past_flags = pos_ff >= POS_W'(2);

   always_comb begin
      pos_in     = pos_ff;
      flags_in   = flags_ff;
      speed_in   = speed_ff;
      cadence_in = cadence_ff;
      power_in   = power_ff;
      if (pos_ff == '0) begin
         flags_in = item.data_byte[FLAG_W-1:0];
      end else if (past_flags) begin
         if (!flags_ff[FLAG_SPEED_ABSENT]) begin
            speed_in = take_byte(speed_ff, pos_ff, lay.speed_at, item.data_byte);
         end
         if (flags_ff[FLAG_CADENCE]) begin
            cadence_in = take_byte(cadence_ff, pos_ff, lay.cadence_at, item.data_byte);
         end
         if (flags_ff[FLAG_POWER]) begin
            power_in = take_byte(power_ff, pos_ff, lay.power_at, item.data_byte);
         end
      end
      if (pos_ff != POS_MAX) begin
         pos_in = pos_ff + POS_W'(1);
      end
   end

   assign len = {1'b0, pos_ff} + (POS_W+1)'(1);
   assign sp  = (pos_ff != '0) && !flags_ff[FLAG_SPEED_ABSENT]
                && (pos_ff > {{(POS_W-OFS_W){1'b0}}, lay.speed_at});
   assign cp  = (pos_ff != '0) && flags_ff[FLAG_CADENCE]
                && (pos_ff > {{(POS_W-OFS_W){1'b0}}, lay.cadence_at});
   assign pp  = (pos_ff != '0) && flags_ff[FLAG_POWER]
                && (pos_ff > {{(POS_W-OFS_W){1'b0}}, lay.power_at});

   always_comb begin
      result.parse_ok        = (pos_ff != '0)
                               && (len >= {{(POS_W+1-OFS_W){1'b0}}, lay.end_at});
      result.speed_present   = sp;
      result.speed_raw       = sp ? speed_in : '0;
      result.cadence_present = cp;
      result.cadence_raw     = cp ? cadence_in : '0;
      result.power_present   = pp;
      result.power_watts     = pp ? power_in : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         flags_ff   <= '0;
         speed_ff   <= '0;
         cadence_ff <= '0;
         power_ff   <= '0;
      end else if (step) begin
         if (item.last_byte) begin
            pos_ff     <= '0;
            flags_ff   <= '0;
            speed_ff   <= '0;
            cadence_ff <= '0;
            power_ff   <= '0;
         end else begin
            pos_ff     <= pos_in;
            flags_ff   <= flags_in;
            speed_ff   <= speed_in;
            cadence_ff <= cadence_in;
            power_ff   <= power_in;
         end
      end
   end

   a_clear_on_last: assert property (@(posedge clock) disable iff (reset)
      step && item.last_byte |=> pos_ff == '0 && flags_ff == '0)
      else $error("parse state not cleared after last item");

   a_pos_count: assert property (@(posedge clock) disable iff (reset)
      step && !item.last_byte && pos_ff != POS_MAX |=> pos_ff == $past(pos_ff) + POS_W'(1))
      else $error("byte position did not advance");

   a_ok_speed: assert property (@(posedge clock) disable iff (reset)
      result.parse_ok && !flags_ff[FLAG_SPEED_ABSENT] |-> result.speed_present)
      else $error("complete notification without flagged speed");

   a_ok_power: assert property (@(posedge clock) disable iff (reset)
      result.parse_ok && flags_ff[FLAG_POWER] |-> result.power_present)
      else $error("complete notification without flagged power");

endmodule

### sv/ibd_output_stage.sv
// result register holding one parsed notification until taken
module ibd_output_stage (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          load,
   input  ibd_pkg::result_type           result,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [ibd_pkg::RSP_DATA_W-1:0] out_data
);
   import ibd_pkg::*;

   logic                  valid_ff;
   logic [RSP_DATA_W-1:0] data_ff;
   logic [RSP_DATA_W-1:0] data_in;

   assign data_in = {{(RSP_DATA_W-52){1'b0}},
                     result.power_watts, result.power_present,
                     result.cadence_raw, result.cadence_present,
                     result.speed_raw, result.speed_present,
                     result.parse_ok};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (out_ready) begin
         valid_ff <= 1'b0;
      end
      if (load) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      load |-> !valid_ff || out_ready)
      else $error("result overwritten before it was taken");

endmodule

### sv/indoor_bike_data_parser.sv
// indoor bike data parser: one notification byte per item, one result per notification
// a result is offered once the item with tlast has passed the input register
// and then the result register
// throughput: one byte per cycle; a stall only when a result is still waiting
// and the next last byte arrives
// reset: synchronous, active high; clears position, flags and captured fields
module indoor_bike_data_parser (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [7:0]                     req_tdata,  // [7:0] data_byte
   input  logic                           req_tlast,  // last_byte
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // [0] parse_ok, [1] speed_present, [17:2] speed_raw, [18] cadence_present,
   // [34:19] cadence_raw, [35] power_present, [51:36] power_watts, [55:52] zero
   output logic [ibd_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import ibd_pkg::*;

   item_type   in_item;
   item_type   hold_item;
   logic       hold_valid;
   logic       step;
   result_type result;

   assign in_item.data_byte = req_tdata;
   assign in_item.last_byte = req_tlast;

   // a last byte moves on only when the result register can take its result
   assign step = hold_valid && (!hold_item.last_byte || !rsp_tvalid || rsp_tready);

   ibd_input_stage u_input (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_item    (in_item),
      .hold_valid (hold_valid),
      .hold_item  (hold_item),
      .advance    (step)
   );

   ibd_parse_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (hold_item),
      .result (result)
   );

   ibd_output_stage u_output (
      .clock     (clock),
      .reset     (reset),
      .load      (step && hold_item.last_byte),
      .result    (result),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_tdata)
   );

   a_last_gives_result: assert property (@(posedge clock) disable iff (reset)
      step && hold_item.last_byte |=> rsp_tvalid)
      else $error("last item gave no result");

   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[RSP_DATA_W-1:52] == '0)
      else $error("result padding not zero");

endmodule

### tb/tb_indoor_bike_data_parser.sv
// self-checking testbench for the indoor bike data parser: directed and random notifications
`timescale 1ns / 100ps

module tb_indoor_bike_data_parser;
   import ibd_pkg::*;

   // tracks the parse of the current notification and holds the results still owed
   class bike_data_scoreboard;
      logic [POS_W-1:0]   position;
      logic [FLAG_W-1:0]  flags;
      logic [VALUE_W-1:0] speed;
      logic [VALUE_W-1:0] cadence;
      logic [VALUE_W-1:0] power;
      result_type         owed_q[$];
      int                 errors;

      function new();
         errors = 0;
         clear();
      endfunction

      function void clear();
         position = '0;
         flags    = '0;
         speed    = '0;
         cadence  = '0;
         power    = '0;
      endfunction

      function int pending();
         return owed_q.size();
      endfunction

      // byte offsets of speed, cadence and power, and the length the flags call for
      function void field_offsets(input logic [FLAG_W-1:0] f, output int speed_at,
                                  output int cadence_at, output int power_at,
                                  output int end_at);
         int at;
         at = 2;
         speed_at = at;
         if (!f[FLAG_SPEED_ABSENT]) at += 2;
         if (f[FLAG_AVG_SPEED]) at += 2;
         cadence_at = at;
         if (f[FLAG_CADENCE]) at += 2;
         if (f[FLAG_AVG_CADENCE]) at += 2;
         if (f[FLAG_DISTANCE]) at += 3;
         if (f[FLAG_RESISTANCE]) at += 2;
         power_at = at;
         if (f[FLAG_POWER]) at += 2;
         end_at = at;
      endfunction

      function logic [VALUE_W-1:0] merge_byte(input logic [VALUE_W-1:0] v, input int p,
                                              input int at, input logic [7:0] b);
         if (p == at) return {v[15:8], b};
         if (p == at + 1) return {b, v[7:0]};
         return v;
      endfunction

      function void note_byte(input logic [7:0] b, input logic last);
         int         p;
         int         len;
         int         speed_at, cadence_at, power_at, end_at;
         result_type r;
         p = position;
         if (p == 0) begin
            flags = b[FLAG_W-1:0];
         end else if (p >= 2) begin
            field_offsets(flags, speed_at, cadence_at, power_at, end_at);
            if (!flags[FLAG_SPEED_ABSENT]) speed = merge_byte(speed, p, speed_at, b);
            if (flags[FLAG_CADENCE]) cadence = merge_byte(cadence, p, cadence_at, b);
            if (flags[FLAG_POWER]) power = merge_byte(power, p, power_at, b);
         end
         if (position != POS_MAX) position++;
         if (!last) return;

         field_offsets(flags, speed_at, cadence_at, power_at, end_at);
         len = p + 1;
         r = '0;
         r.parse_ok        = (len >= 2) && (len >= end_at);
         r.speed_present   = (len >= 2) && !flags[FLAG_SPEED_ABSENT] && (len >= speed_at + 2);
         r.cadence_present = (len >= 2) && flags[FLAG_CADENCE] && (len >= cadence_at + 2);
         r.power_present   = (len >= 2) && flags[FLAG_POWER] && (len >= power_at + 2);
         if (r.speed_present) r.speed_raw = speed;
         if (r.cadence_present) r.cadence_raw = cadence;
         if (r.power_present) r.power_watts = power;
         owed_q.push_back(r);
         clear();
      endfunction

      task report_mismatch(input string msg);
         $display("%0t mismatch: %s", $realtime, msg);
         errors++;
      endtask

      task compare_field(input string name, input logic [15:0] got, input logic [15:0] want);
         if (got !== want)
            report_mismatch($sformatf("%s got %h expected %h", name, got, want));
      endtask

      task check_result(input logic [RSP_DATA_W-1:0] d);
         result_type w;
         if (owed_q.size() == 0) begin
            report_mismatch($sformatf("result %h with no notification pending", d));
            return;
         end
         w = owed_q.pop_front();
         compare_field("parse_ok", d[0], w.parse_ok);
         compare_field("speed_present", d[1], w.speed_present);
         compare_field("speed_raw", d[17:2], w.speed_raw);
         compare_field("cadence_present", d[18], w.cadence_present);
         compare_field("cadence_raw", d[34:19], w.cadence_raw);
         compare_field("power_present", d[35], w.power_present);
         compare_field("power_watts", d[51:36], w.power_watts);
         compare_field("padding", d[55:52], 4'h0);
      endtask
   endclass

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata  = 8'h00;
   logic                  req_tlast  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   int tx_idle_pct    = 0;
   int rx_stall_pct   = 0;
   int hold_cycles    = 0;
   int bytes_accepted = 0;

   bike_data_scoreboard parse_sb = new();

   indoor_bike_data_parser dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("[indoor_bike_data_parser] ERROR");
      $finish;
   end

   // result side: check on handshake, then pick ready for the next cycle
   initial begin
      wait (reset === 1'b0);
      forever begin
         @(posedge clock);
         if (rsp_tvalid === 1'b1 && rsp_tready === 1'b1) parse_sb.check_result(rsp_tdata);
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= rx_stall_pct);
         end
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic last);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      do @(posedge clock); while (req_tready !== 1'b1);
      parse_sb.note_byte(b, last);
      bytes_accepted++;
   endtask

   task automatic send_list(input logic [7:0] msg[$]);
      for (int i = 0; i < msg.size(); i++) send_byte(msg[i], i == msg.size() - 1);
   endtask

   task automatic send_notification(input logic [15:0] f, input int len);
      logic [7:0] msg[$];
      for (int i = 0; i < len; i++) begin
         if (i == 0) msg.push_back(f[7:0]);
         else if (i == 1) msg.push_back(f[15:8]);
         else msg.push_back(8'($urandom_range(255)));
      end
      send_list(msg);
   endtask

   // mostly complete notifications, some cut short, some arbitrary length
   task automatic random_notification();
      logic [15:0] f;
      int          speed_at, cadence_at, power_at, end_at;
      int          len;
      int          pick;
      f = 16'($urandom_range(16'hFFFF));
      parse_sb.field_offsets(f[FLAG_W-1:0], speed_at, cadence_at, power_at, end_at);
      pick = $urandom_range(99);
      if (pick < 75)
         len = end_at + (($urandom_range(3) == 0) ? $urandom_range(1, 4) : 0);
      else if (pick < 90)
         len = (end_at > 2) ? $urandom_range(1, end_at - 1) : 1;
      else
         len = $urandom_range(1, 24);
      send_notification(f, len);
   endtask

   task automatic wait_drain();
      @(posedge clock);
      while (parse_sb.pending() != 0) @(posedge clock);
   endtask

   task automatic run_phase(input int tx_pct, input int rx_pct, input int nbytes);
      int start;
      tx_idle_pct  = tx_pct;
      rx_stall_pct = rx_pct;
      start = bytes_accepted;
      while (bytes_accepted - start < nbytes) random_notification();
      req_tvalid <= 1'b0;
      wait_drain();
   endtask

   initial begin
      logic [7:0] msg[$];
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // short notification: only one byte
      msg = '{8'h00};
      send_list(msg);
      // all flags and high flag byte set, cut off right after the flags
      msg = '{8'hFF, 8'hFF};
      send_list(msg);
      // speed only, largest value
      msg = '{8'h00, 8'h00, 8'hFF, 8'hFF};
      send_list(msg);
      // speed, cadence and most negative power
      msg = '{8'h44, 8'h00, 8'h00, 8'h00, 8'h34, 8'h12, 8'h00, 8'h80};
      send_list(msg);
      // power cut in half, speed absent
      msg = '{8'h41, 8'h80, 8'h05};
      send_list(msg);
      // largest power followed by bytes that must be ignored
      msg = '{8'h41, 8'h00, 8'hFF, 8'h7F, 8'hAA, 8'hBB};
      send_list(msg);
      req_tvalid <= 1'b0;
      wait_drain();

      // notification long enough to saturate the position counter
      send_notification(16'h007E, 270);
      run_phase(0, 0, 130);

      // receiver holds off while the sender keeps going, so the input stalls
      hold_cycles = 250;
      repeat (6) random_notification();
      req_tvalid <= 1'b0;
      wait_drain();

      run_phase(88, 0, 130);
      run_phase(0, 88, 130);
      run_phase(22, 22, 130);

      rx_stall_pct = 0;
      repeat (20) @(posedge clock);
      if (parse_sb.errors == 0 && parse_sb.pending() == 0)
         $display("[indoor_bike_data_parser] OK");
      else
         $display("[indoor_bike_data_parser] ERROR");
      $finish;
   end

endmodule
